### src/rvr_pkg.sv
// Package for the rotor vector rotation block.
// Holds fixed widths and the control struct shared by the divider stages.
// No dependencies.
package rvr_pkg;

  // Rotor parts are signed Q2.14.
  localparam int unsigned ROTOR_W = 16;
  // Squared magnitude: sum of four squares of 16-bit values.
  localparam int unsigned MAG_W = 2 * ROTOR_W + 1;
  localparam int unsigned LANES = 3;

  // Per-item flags that ride along with the divider stages.
  typedef struct packed {
    logic             zero;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] ovf;
  } rvr_ctrl_t;

endpackage

### src/rvr_item_if.sv
// Valid/ready channel interfaces for rotation requests and results.
// Depends on rvr_pkg for the rotor width.
interface rvr_item_if #(
  parameter int unsigned VECTOR_WIDTH = 16
);
  import rvr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [ROTOR_W-1:0]  rotor_s;
  logic signed [ROTOR_W-1:0]  rotor_yz;
  logic signed [ROTOR_W-1:0]  rotor_zx;
  logic signed [ROTOR_W-1:0]  rotor_xy;
  logic signed [VECTOR_WIDTH-1:0] vec_x;
  logic signed [VECTOR_WIDTH-1:0] vec_y;
  logic signed [VECTOR_WIDTH-1:0] vec_z;

  modport source (output valid, rotor_s, rotor_yz, rotor_zx, rotor_xy, vec_x, vec_y, vec_z,
                  input ready);
  modport sink (input valid, rotor_s, rotor_yz, rotor_zx, rotor_xy, vec_x, vec_y, vec_z,
                output ready);
endinterface

interface rvr_result_if #(
  parameter int unsigned VECTOR_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [VECTOR_WIDTH-1:0] out_x;
  logic signed [VECTOR_WIDTH-1:0] out_y;
  logic signed [VECTOR_WIDTH-1:0] out_z;
  logic                           zero_rotor;
  logic                           clipped;

  modport source (output valid, out_x, out_y, out_z, zero_rotor, clipped, input ready);
  modport sink (input valid, out_x, out_y, out_z, zero_rotor, clipped, output ready);
endinterface

### src/rvr_div_step.sv
// One restoring-division stage: resolves quotient bit SHIFT for all three lanes.
// Depends on rvr_pkg.
module rvr_div_step #(
  parameter int unsigned VECTOR_WIDTH = 16,
  parameter int unsigned NUM_W = 52,
  parameter int unsigned SHIFT = 0
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  logic                                       v_in,
  input  logic [rvr_pkg::LANES-1:0][NUM_W-1:0]       rem_in,
  input  logic [rvr_pkg::LANES-1:0][VECTOR_WIDTH:0]  quot_in,
  input  logic [rvr_pkg::MAG_W-1:0]                  mag_in,
  input  rvr_pkg::rvr_ctrl_t                         ctrl_in,
  output logic                                       v_out,
  output logic [rvr_pkg::LANES-1:0][NUM_W-1:0]       rem_out,
  output logic [rvr_pkg::LANES-1:0][VECTOR_WIDTH:0]  quot_out,
  output logic [rvr_pkg::MAG_W-1:0]                  mag_out,
  output rvr_pkg::rvr_ctrl_t                         ctrl_out
);
  import rvr_pkg::*;

  logic [NUM_W-1:0]                      divisor;
  logic [LANES-1:0][NUM_W-1:0]           rem_next;
  logic [LANES-1:0][VECTOR_WIDTH:0]      quot_next;

  assign divisor = NUM_W'(mag_in) << SHIFT;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_next[l]  = rem_in[l];
      quot_next[l] = quot_in[l];
      if (rem_in[l] >= divisor) begin
        rem_next[l]        = rem_in[l] - divisor;
        quot_next[l][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      quot_out <= quot_next;
      mag_out  <= mag_in;
      ctrl_out <= ctrl_in;
    end
  end
endmodule

### src/rotor_vector_rotate.sv
// Top level of the rotor vector rotation pipeline.
// Depends on rvr_pkg, rvr_item_if, rvr_result_if and rvr_div_step.

// Rotates a vector by a rotor through the sandwich product and divides by the
// rotor's squared magnitude, truncating toward zero and saturating. One
// transaction is taken every clock while no stall holds the pipeline. It has
// six arithmetic stages, a divider that resolves one quotient bit per stage
// (VECTOR_WIDTH + 1 stages) and the output register. Each stage holds its item
// while the next cannot load, so bubbles close up under back-pressure.
module rotor_vector_rotate #(
  parameter int unsigned VECTOR_WIDTH = 16
) (
  input logic clk,
  input logic rst,
  rvr_item_if.sink     item,
  rvr_result_if.source result
);
  import rvr_pkg::*;

  localparam int unsigned VW   = VECTOR_WIDTH;
  localparam int unsigned SQ_W = 2 * ROTOR_W;
  localparam int unsigned P1_W = VW + ROTOR_W;
  localparam int unsigned S_W  = P1_W + 2;
  localparam int unsigned P2_W = S_W + ROTOR_W;
  localparam int unsigned N_W  = P2_W + 2;
  localparam int unsigned DIV_N = VW + 1;

  // Stage enables: a stage loads when it is empty or the next one loads.
  logic e1, e2, e3, e4, e5, e6, eo;
  logic v1, v2, v3, v4, v5, v6;

  // Stage 1: vector products and squares.
  logic signed [P1_W-1:0]    p1 [12];
  logic [SQ_W-1:0]           sq1 [4];
  logic signed [ROTOR_W-1:0] r1 [4];

  // Stage 2: intermediate sums and magnitude.
  logic signed [S_W-1:0]     s2 [4];
  logic [MAG_W-1:0]          m2;
  logic signed [ROTOR_W-1:0] r2 [4];

  // Stage 3: sandwich products.
  logic signed [P2_W-1:0]    p3 [12];
  logic [MAG_W-1:0]          m3;

  // Stage 4: numerators.
  logic signed [N_W-1:0]     n4 [LANES];
  logic [MAG_W-1:0]          m4;

  // Stage 5: sign and magnitude.
  logic [LANES-1:0][N_W-1:0] a5;
  logic [LANES-1:0]          neg5;
  logic [MAG_W-1:0]          m5;

  // Stage 6: overflow precheck, divider input.
  logic [LANES-1:0][N_W-1:0] a6;
  rvr_ctrl_t                 c6;
  logic [MAG_W-1:0]          m6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (e1) v1 <= item.valid;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
      if (e4) v4 <= v3;
      if (e5) v5 <= v4;
      if (e6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      p1[0]  <= P1_W'(item.rotor_s)  * P1_W'(item.vec_x);
      p1[1]  <= P1_W'(item.rotor_xy) * P1_W'(item.vec_y);
      p1[2]  <= P1_W'(item.rotor_zx) * P1_W'(item.vec_z);
      p1[3]  <= P1_W'(item.rotor_s)  * P1_W'(item.vec_y);
      p1[4]  <= P1_W'(item.rotor_xy) * P1_W'(item.vec_x);
      p1[5]  <= P1_W'(item.rotor_yz) * P1_W'(item.vec_z);
      p1[6]  <= P1_W'(item.rotor_s)  * P1_W'(item.vec_z);
      p1[7]  <= P1_W'(item.rotor_yz) * P1_W'(item.vec_y);
      p1[8]  <= P1_W'(item.rotor_zx) * P1_W'(item.vec_x);
      p1[9]  <= P1_W'(item.rotor_xy) * P1_W'(item.vec_z);
      p1[10] <= P1_W'(item.rotor_yz) * P1_W'(item.vec_x);
      p1[11] <= P1_W'(item.rotor_zx) * P1_W'(item.vec_y);
      sq1[0] <= unsigned'(SQ_W'(item.rotor_s)  * SQ_W'(item.rotor_s));
      sq1[1] <= unsigned'(SQ_W'(item.rotor_yz) * SQ_W'(item.rotor_yz));
      sq1[2] <= unsigned'(SQ_W'(item.rotor_zx) * SQ_W'(item.rotor_zx));
      sq1[3] <= unsigned'(SQ_W'(item.rotor_xy) * SQ_W'(item.rotor_xy));
      r1[0]  <= item.rotor_s;
      r1[1]  <= item.rotor_yz;
      r1[2]  <= item.rotor_zx;
      r1[3]  <= item.rotor_xy;
    end
    if (e2) begin
      s2[0] <= S_W'(p1[0]) + S_W'(p1[1]) - S_W'(p1[2]);
      s2[1] <= S_W'(p1[3]) - S_W'(p1[4]) + S_W'(p1[5]);
      s2[2] <= S_W'(p1[6]) - S_W'(p1[7]) + S_W'(p1[8]);
      s2[3] <= S_W'(p1[9]) + S_W'(p1[10]) + S_W'(p1[11]);
      m2    <= MAG_W'(sq1[0]) + MAG_W'(sq1[1]) + MAG_W'(sq1[2]) + MAG_W'(sq1[3]);
      r2    <= r1;
    end
    // s2 order: Sx, Sy, Sz, Sxyz. r2 order: s, yz, zx, xy.
    if (e3) begin
      p3[0]  <= P2_W'(s2[0]) * P2_W'(r2[0]);
      p3[1]  <= P2_W'(s2[1]) * P2_W'(r2[3]);
      p3[2]  <= P2_W'(s2[3]) * P2_W'(r2[1]);
      p3[3]  <= P2_W'(s2[2]) * P2_W'(r2[2]);
      p3[4]  <= P2_W'(s2[1]) * P2_W'(r2[0]);
      p3[5]  <= P2_W'(s2[0]) * P2_W'(r2[3]);
      p3[6]  <= P2_W'(s2[2]) * P2_W'(r2[1]);
      p3[7]  <= P2_W'(s2[3]) * P2_W'(r2[2]);
      p3[8]  <= P2_W'(s2[2]) * P2_W'(r2[0]);
      p3[9]  <= P2_W'(s2[3]) * P2_W'(r2[3]);
      p3[10] <= P2_W'(s2[1]) * P2_W'(r2[1]);
      p3[11] <= P2_W'(s2[0]) * P2_W'(r2[2]);
      m3     <= m2;
    end
    if (e4) begin
      n4[0] <= N_W'(p3[0]) + N_W'(p3[1]) + N_W'(p3[2]) - N_W'(p3[3]);
      n4[1] <= N_W'(p3[4]) - N_W'(p3[5]) + N_W'(p3[6]) + N_W'(p3[7]);
      n4[2] <= N_W'(p3[8]) + N_W'(p3[9]) - N_W'(p3[10]) + N_W'(p3[11]);
      m4    <= m3;
    end
    if (e5) begin
      for (int l = 0; l < LANES; l++) begin
        neg5[l] <= n4[l][N_W-1];
        a5[l]   <= n4[l][N_W-1] ? unsigned'(-n4[l]) : unsigned'(n4[l]);
      end
      m5 <= m4;
    end
    if (e6) begin
      // A magnitude at or above M * 2^(VW+1) cannot fit the quotient bits.
      for (int l = 0; l < LANES; l++) begin
        c6.ovf[l] <= a5[l] >= (N_W'(m5) << DIV_N);
      end
      c6.neg  <= neg5;
      c6.zero <= (m5 == '0);
      a6      <= a5;
      m6      <= m5;
    end
  end

  // Divider chain: stage k resolves quotient bit VW - k.
  logic                                vd   [DIV_N+1];
  logic                                ed   [DIV_N];
  logic [LANES-1:0][N_W-1:0]           remd [DIV_N+1];
  logic [LANES-1:0][VW:0]              quod [DIV_N+1];
  logic [MAG_W-1:0]                    magd [DIV_N+1];
  rvr_ctrl_t                           ctld [DIV_N+1];

  assign vd[0]   = v6;
  assign remd[0] = a6;
  assign quod[0] = '0;
  assign magd[0] = m6;
  assign ctld[0] = c6;

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    if (k == DIV_N - 1) begin : g_last
      assign ed[k] = !vd[k+1] || eo;
    end else begin : g_mid
      assign ed[k] = !vd[k+1] || ed[k+1];
    end
    rvr_div_step #(
      .VECTOR_WIDTH (VW),
      .NUM_W        (N_W),
      .SHIFT        (VW - k)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (ed[k]),
      .v_in     (vd[k]),
      .rem_in   (remd[k]),
      .quot_in  (quod[k]),
      .mag_in   (magd[k]),
      .ctrl_in  (ctld[k]),
      .v_out    (vd[k+1]),
      .rem_out  (remd[k+1]),
      .quot_out (quod[k+1]),
      .mag_out  (magd[k+1]),
      .ctrl_out (ctld[k+1])
    );
  end

  assign eo = !result.valid || result.ready;
  assign e6 = !v6 || ed[0];
  assign e5 = !v5 || e6;
  assign e4 = !v4 || e5;
  assign e3 = !v3 || e4;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;
  assign item.ready = e1;

  // Saturation and output register.
  localparam logic [VW:0] HALF = (VW + 1)'(1) << (VW - 1);

  rvr_ctrl_t                cf;
  logic [LANES-1:0][VW:0]   qf;
  logic [LANES-1:0][VW-1:0] res_next;
  logic [LANES-1:0]         sat;

  assign cf = ctld[DIV_N];
  assign qf = quod[DIV_N];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sat[l]      = 1'b0;
      res_next[l] = '0;
      if (cf.neg[l]) begin
        if (cf.ovf[l] || qf[l] > HALF) begin
          sat[l]      = 1'b1;
          res_next[l] = VW'(HALF);
        end else begin
          res_next[l] = VW'(-qf[l]);
        end
      end else begin
        if (cf.ovf[l] || qf[l] > HALF - 1'b1) begin
          sat[l]      = 1'b1;
          res_next[l] = VW'(HALF - 1'b1);
        end else begin
          res_next[l] = VW'(qf[l]);
        end
      end
      if (cf.zero) begin
        sat[l]      = 1'b0;
        res_next[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (eo) begin
      result.valid <= vd[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (eo) begin
      result.out_x      <= res_next[0];
      result.out_y      <= res_next[1];
      result.out_z      <= res_next[2];
      result.zero_rotor <= cf.zero;
      result.clipped    <= |sat;
    end
  end

  // The input stalls only when every stage is full behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (result.valid && !result.ready))
    else $error("input stalled without output back-pressure");

  // A zero rotor yields a zero vector and no clipping.
  a_zero_rotor: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.zero_rotor) |->
      (result.out_x == '0 && result.out_y == '0 && result.out_z == '0 && !result.clipped))
    else $error("zero rotor result not cleared");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
endmodule
